// ----- design/rce_pkg.sv -----
// shared constants and types for the roberts cross edge stream core
// no dependencies

package rce_pkg;

    localparam int DEFAULT_MAX_WIDTH = 2048;
    localparam int MAX_HEIGHT        = 4096;

    localparam int PIX_W    = 8;
    localparam int FW_W     = 12;
    localparam int FH_W     = 13;
    localparam int ROW_W    = 12;
    localparam int CFG_W    = 13;
    localparam int CFG_IDX_W = 1;

    localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 12'd640;
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 13'd480;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

    // control carried alongside an item from the input register to the result register
    typedef struct packed {
        logic pix_op;
        logic emit;
        logic border;
        logic last;
    } stage_ctl_t;

endpackage

// ----- design/roberts_cross_edge_stream_core.sv -----
// roberts cross edge stream core: line buffers, diagonal taps, position counters
// depends on rce_pkg
//
// an accepted item passes the stage 1 register, then the result register
// throughput: one item per cycle unless the output stalls
// reset: counters, taps and handshake state clear; size registers load 640 x 480;
// line buffer contents stay undefined until written

module roberts_cross_edge_stream_core #(
    parameter int MAX_WIDTH = rce_pkg::DEFAULT_MAX_WIDTH
) (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          cfg_we,
    input  logic [rce_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rce_pkg::CFG_W-1:0]     cfg_data,

    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,   // [7:0] pixel
    input  logic                          s_axis_tuser,   // [0] drain

    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [7:0]                    m_axis_tdata,   // [7:0] edge_value
    output logic                          m_axis_tlast
);
    import rce_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int EW = $clog2(MAX_WIDTH + 1);

    // configuration
    logic [FW_W-1:0] frame_width_reg;
    logic [FH_W-1:0] frame_height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[FW_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data[FH_W-1:0];
                default: ;
            endcase
        end
    end

    logic [EW-1:0]   eff_w;
    logic [FH_W-1:0] eff_h;

    always_comb
    begin
        if (frame_width_reg == '0)
            eff_w = EW'(1);
        else if (32'(frame_width_reg) > MAX_WIDTH)
            eff_w = EW'(MAX_WIDTH);
        else
            eff_w = EW'(frame_width_reg);

        if (frame_height_reg == '0)
            eff_h = FH_W'(1);
        else if (32'(frame_height_reg) > MAX_HEIGHT)
            eff_h = FH_W'(MAX_HEIGHT);
        else
            eff_h = frame_height_reg;
    end

    // position state
    logic [ROW_W-1:0] in_row_reg,  in_row_next;
    logic [CW-1:0]    in_col_reg,  in_col_next;
    logic [ROW_W-1:0] out_row_reg, out_row_next;
    logic [CW-1:0]    out_col_reg, out_col_next;
    logic             done_reg,    done_next;

    // stage 1: item with line buffer read
    logic             s1_valid_reg, s1_valid_next;
    stage_ctl_t       s1_ctl_reg;
    logic [PIX_W-1:0] s1_pix_reg;
    logic [CW-1:0]    s1_idx_reg;

    // result register
    logic             out_valid_reg, out_valid_next;
    logic [PIX_W-1:0] out_data_reg;
    logic             out_last_reg;

    logic       s1_adv;
    logic       accept;
    logic       pix_op;
    logic       out_op;
    logic       emit;
    logic       in_col_wrap;
    logic       in_row_wrap;
    logic       out_col_end;
    logic       out_row_end;
    logic       border;
    logic       last;
    stage_ctl_t ctl;

    assign s1_adv        = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || s1_adv;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        pix_op      = !done_reg && !s_axis_tuser;
        emit        = (in_row_reg >= ROW_W'(2)) ||
                      ((in_row_reg == ROW_W'(1)) && (in_col_reg != '0));
        out_op      = done_reg || (pix_op && emit);
        in_col_wrap = (EW'(in_col_reg) + EW'(1)) >= eff_w;
        in_row_wrap = (FH_W'(in_row_reg) + FH_W'(1)) >= eff_h;
        out_col_end = (EW'(out_col_reg) + EW'(1)) >= eff_w;
        out_row_end = (FH_W'(out_row_reg) + FH_W'(1)) >= eff_h;
        border      = (out_row_reg == '0) || out_row_end || (out_col_reg == '0) || out_col_end;
        last        = out_row_end && out_col_end;

        ctl.pix_op  = pix_op;
        ctl.emit    = out_op;
        ctl.border  = border;
        ctl.last    = last;

        in_row_next  = in_row_reg;
        in_col_next  = in_col_reg;
        out_row_next = out_row_reg;
        out_col_next = out_col_reg;
        done_next    = done_reg;

        if (accept && pix_op)
        begin
            if (in_col_wrap)
            begin
                in_col_next = '0;
                if (in_row_wrap)
                begin
                    in_row_next = '0;
                    done_next   = 1'b1;
                end
                else
                begin
                    in_row_next = in_row_reg + ROW_W'(1);
                end
            end
            else
            begin
                in_col_next = in_col_reg + CW'(1);
            end
        end

        if (accept && out_op)
        begin
            if (last)
            begin
                in_row_next  = '0;
                in_col_next  = '0;
                out_row_next = '0;
                out_col_next = '0;
                done_next    = 1'b0;
            end
            else if (out_col_end)
            begin
                out_col_next = '0;
                out_row_next = out_row_reg + ROW_W'(1);
            end
            else
            begin
                out_col_next = out_col_reg + CW'(1);
            end
        end

        // a drain item before the frame is in leaves no trace
        if (accept)
            s1_valid_next = pix_op || done_reg;
        else if (s1_adv)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;

        if (s1_adv && s1_ctl_reg.emit)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // line buffer: each entry holds {upper, middle} of one column
    logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] rd_reg;
    logic [2*PIX_W-1:0] fwd_reg;
    logic               byp_reg;
    logic [2*PIX_W-1:0] line_rd;
    logic [2*PIX_W-1:0] line_wr;
    logic               mem_we;
    logic               mem_re;

    assign mem_re  = accept && pix_op;
    assign mem_we  = s1_adv && s1_ctl_reg.pix_op;
    assign line_rd = byp_reg ? fwd_reg : rd_reg;
    assign line_wr = {line_rd[PIX_W-1:0], s1_pix_reg};

    always_ff @(posedge clk)
    begin
        if (mem_we)
            line_mem[s1_idx_reg] <= line_wr;
        if (mem_re)
        begin
            rd_reg  <= line_mem[in_col_reg];
            // same column written this edge (single column rows)
            byp_reg <= mem_we && (s1_idx_reg == in_col_reg);
            fwd_reg <= line_wr;
        end
    end

    // diagonal taps and magnitude
    logic [PIX_W-1:0] upper_tap0_reg, upper_tap1_reg;
    logic [PIX_W-1:0] lower_tap0_reg, lower_tap1_reg;
    logic [PIX_W-1:0] upper_px;
    logic [PIX_W-1:0] d1;
    logic [PIX_W-1:0] d2;
    logic [PIX_W-1:0] mag;

    always_comb
    begin
        upper_px = line_rd[2*PIX_W-1:PIX_W];
        d1 = (upper_tap1_reg > s1_pix_reg) ? upper_tap1_reg - s1_pix_reg
                                           : s1_pix_reg - upper_tap1_reg;
        d2 = (upper_px > lower_tap1_reg) ? upper_px - lower_tap1_reg
                                         : lower_tap1_reg - upper_px;
        mag = (d1 > d2) ? d1 : d2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_row_reg     <= '0;
            in_col_reg     <= '0;
            out_row_reg    <= '0;
            out_col_reg    <= '0;
            done_reg       <= 1'b0;
            s1_valid_reg   <= 1'b0;
            s1_ctl_reg     <= '0;
            out_valid_reg  <= 1'b0;
            upper_tap0_reg <= '0;
            upper_tap1_reg <= '0;
            lower_tap0_reg <= '0;
            lower_tap1_reg <= '0;
        end
        else
        begin
            in_row_reg    <= in_row_next;
            in_col_reg    <= in_col_next;
            out_row_reg   <= out_row_next;
            out_col_reg   <= out_col_next;
            done_reg      <= done_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (accept)
                s1_ctl_reg <= ctl;
            if (mem_we)
            begin
                upper_tap1_reg <= upper_tap0_reg;
                upper_tap0_reg <= upper_px;
                lower_tap1_reg <= lower_tap0_reg;
                lower_tap0_reg <= s1_pix_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg <= s_axis_tdata;
            s1_idx_reg <= in_col_reg;
        end
        if (s1_adv && s1_ctl_reg.emit)
        begin
            // drain results always fall on the border
            out_data_reg <= (s1_ctl_reg.border || !s1_ctl_reg.pix_op) ? '0 : mag;
            out_last_reg <= s1_ctl_reg.last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule
